// ===== hdl/bba_pkg.sv =====
// Shared types and result status codes for the buddy block allocator.
package bba_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_HANDLE_BUSY = 3'd1;
    localparam status_t ST_BAD_SIZE    = 3'd2;
    localparam status_t ST_NO_SPACE    = 3'd3;
    localparam status_t ST_NOT_HELD    = 3'd4;

endpackage

// ===== hdl/bba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: sequencer, free store and handle table.
// One transfer is taken at a time and stall stays high until its result is registered.
// The free store holds one bit per order and aligned start in a RAM with a registered
// read port. A reserve steps up the orders to find the size, then scans the entries
// of each order from the lowest address upwards, with a read state and a check state
// per entry, and splits one order per step; a free steps up to the region's order,
// then reads each buddy and merges while the buddy is free. After reset and after
// every write of block_count a clearing pass rebuilds the free store, one entry a
// cycle over the sum of BLOCKS >> k for k from 0 to MAX_ORDER (2047 entries at the
// defaults), during which no transfer is accepted.
module buddy_block_allocator #(
    parameter int BLOCKS    = 1024,
    parameter int MAX_ORDER = 10,
    parameter int HANDLES   = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          block_count_we,
    input  logic [10:0]                   block_count,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          func,
    input  logic [7:0]                    handle,
    input  logic [10:0]                   request_size,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bba_pkg::status_t              status,
    output logic [$clog2(BLOCKS)-1:0]     start_block,
    output logic [$clog2(MAX_ORDER+1)-1:0] order
);

    import bba_pkg::*;

    function automatic int depth_of();
        int d;
        d = 0;
        for (int j = 0; j <= MAX_ORDER; j++)
        begin
            d = d + (BLOCKS >> j);
        end
        return d;
    endfunction

    localparam int DEPTH = depth_of();
    localparam int AW    = $clog2(BLOCKS);
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int KW    = $clog2(MAX_ORDER + 2);
    localparam int DAW   = $clog2(DEPTH);
    localparam int BW    = $clog2(DEPTH + 1);
    localparam int HIW   = $clog2(HANDLES);

    localparam logic [AW:0]   BLOCKS_W  = (AW+1)'(BLOCKS);
    localparam logic [17:0]   BLOCKS_18 = 18'(BLOCKS);
    localparam logic [17:0]   MAXSZ_18  = 18'(1) << MAX_ORDER;
    localparam logic [12:0]   HANDLES_W = 13'(HANDLES);
    localparam logic [KW-1:0] MAX_K     = KW'(MAX_ORDER);

    localparam logic [3:0] S_SWEEP     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_HMOD      = 4'd2;
    localparam logic [3:0] S_CHECK     = 4'd3;
    localparam logic [3:0] S_PCALC     = 4'd4;
    localparam logic [3:0] S_SRCH_RD   = 4'd5;
    localparam logic [3:0] S_SRCH_CHK  = 4'd6;
    localparam logic [3:0] S_SPLIT     = 4'd7;
    localparam logic [3:0] S_FREE_RD   = 4'd8;
    localparam logic [3:0] S_FREE_BASE = 4'd9;
    localparam logic [3:0] S_MERGE_RD  = 4'd10;
    localparam logic [3:0] S_MERGE_CHK = 4'd11;
    localparam logic [3:0] S_MERGE_END = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [10:0]   bc_reg;
    logic          func_reg, func_next;
    logic [7:0]    h_reg, h_next;
    logic [10:0]   size_reg, size_next;
    logic [KW-1:0] p_reg, p_next;
    logic [KW-1:0] q_reg, q_next;
    logic [BW-1:0] base_reg, base_next;
    logic [AW:0]   i_reg, i_next;
    logic [AW-1:0] s_reg, s_next;
    logic [KW-1:0] k_reg, k_next;
    logic [DAW-1:0] sw_addr_reg;
    logic [AW:0]   sw_i_reg;
    logic [KW-1:0] sw_k_reg;
    status_t       res_status_reg, res_status_next;
    logic [AW-1:0] res_start_reg, res_start_next;
    logic [OW-1:0] res_order_reg, res_order_next;
    logic          rsp_valid_reg;
    status_t       rsp_status_reg;
    logic [AW-1:0] rsp_start_reg;
    logic [OW-1:0] rsp_order_reg;
    logic [HANDLES-1:0] hvalid_reg;

    logic           fr_we, fr_wdata, fr_rdata;
    logic [DAW-1:0] fr_waddr, fr_raddr;
    logic           ht_we;
    logic [AW+OW-1:0] ht_wdata, ht_rdata;
    logic [HIW-1:0] hidx;
    logic           set_valid, clr_valid;

    logic [AW:0]   lim_q, lim_qm1, lim_k, lim_p;
    logic [AW:0]   bidx, sidx;
    logic [KW-1:0] qm1;
    logic [BW-1:0] base_dn;
    logic [17:0]   n18, pow_p;
    logic [AW+1:0] n_ext, sw_s, sw_e, n_hi, n_sh;
    logic [KW-1:0] sw_k1;
    logic          sw_free;
    logic [AW:0]   sw_lim;

    function automatic logic [DAW-1:0] addr_of(input logic [BW-1:0] b, input logic [AW:0] ix);
        logic [BW+AW+1:0] sum;
        sum = (BW+AW+2)'(b) + (BW+AW+2)'(ix);
        return sum[DAW-1:0];
    endfunction

    assign hidx    = HIW'(h_reg);
    assign lim_q   = BLOCKS_W >> q_reg;
    assign qm1     = q_reg - KW'(1);
    assign lim_qm1 = BLOCKS_W >> qm1;
    assign base_dn = base_reg - BW'(lim_qm1);
    assign lim_k   = BLOCKS_W >> k_reg;
    assign lim_p   = BLOCKS_W >> p_reg;
    assign bidx    = (AW+1)'(s_reg >> k_reg) ^ (AW+1)'(1);
    assign sidx    = (AW+1)'(s_reg >> k_reg);
    assign pow_p   = 18'(1) << p_reg;

    assign n18    = (18'(bc_reg) > BLOCKS_18) ? BLOCKS_18 : 18'(bc_reg);
    assign n_ext  = (AW+2)'(n18);
    assign sw_s   = (AW+2)'(sw_i_reg) << sw_k_reg;
    assign sw_e   = ((AW+2)'(sw_i_reg) + (AW+2)'(1)) << sw_k_reg;
    assign sw_k1  = sw_k_reg + KW'(1);
    assign n_hi   = (n_ext >> sw_k1) << sw_k1;
    assign n_sh   = n_ext >> sw_k_reg;
    assign sw_lim = BLOCKS_W >> sw_k_reg;
    assign sw_free = (sw_k_reg == MAX_K) ? (sw_e <= n_ext) : (n_sh[0] && (sw_s == n_hi));

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        h_next          = h_reg;
        size_next       = size_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_order_next  = res_order_reg;
        fr_we           = 1'b0;
        fr_wdata        = 1'b0;
        fr_waddr        = sw_addr_reg;
        fr_raddr        = addr_of(base_reg, i_reg);
        ht_we           = 1'b0;
        ht_wdata        = {s_reg, OW'(p_reg)};
        set_valid       = 1'b0;
        clr_valid       = 1'b0;
        unique case (state_reg)
            S_SWEEP:
            begin
                fr_we    = 1'b1;
                fr_wdata = sw_free;
                if (sw_addr_reg == DAW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = func;
                    h_next     = handle;
                    size_next  = request_size;
                    state_next = S_HMOD;
                end
            end
            S_HMOD:
            begin
                if (13'(h_reg) >= HANDLES_W)
                begin
                    h_next = 8'(13'(h_reg) - HANDLES_W);
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_start_next = '0;
                res_order_next = '0;
                res_status_next = ST_OK;
                p_next    = '0;
                base_next = '0;
                if (func_reg)
                begin
                    if (!hvalid_reg[hidx])
                    begin
                        res_status_next = ST_NOT_HELD;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
                else if (hvalid_reg[hidx])
                begin
                    res_status_next = ST_HANDLE_BUSY;
                    state_next      = S_DONE;
                end
                else if (size_reg == 11'd0)
                begin
                    res_status_next = ST_BAD_SIZE;
                    state_next      = S_DONE;
                end
                else if (18'(size_reg) > MAXSZ_18)
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_PCALC;
                end
            end
            S_PCALC:
            begin
                if (pow_p < 18'(size_reg))
                begin
                    base_next = base_reg + BW'(lim_p);
                    p_next    = p_reg + KW'(1);
                end
                else
                begin
                    q_next     = p_reg;
                    i_next     = '0;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (q_reg > MAX_K)
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
                else if (i_reg >= lim_q)
                begin
                    base_next = base_reg + BW'(lim_q);
                    q_next    = q_reg + KW'(1);
                    i_next    = '0;
                end
                else
                begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (fr_rdata)
                begin
                    fr_we      = 1'b1;
                    fr_waddr   = addr_of(base_reg, i_reg);
                    fr_wdata   = 1'b0;
                    s_next     = AW'(i_reg << q_reg);
                    state_next = S_SPLIT;
                end
                else
                begin
                    i_next     = i_reg + (AW+1)'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_SPLIT:
            begin
                if (q_reg > p_reg)
                begin
                    fr_we     = 1'b1;
                    fr_wdata  = 1'b1;
                    fr_waddr  = addr_of(base_dn, (AW+1)'(s_reg >> qm1) | (AW+1)'(1));
                    q_next    = qm1;
                    base_next = base_dn;
                end
                else
                begin
                    ht_we          = 1'b1;
                    set_valid      = 1'b1;
                    res_start_next = s_reg;
                    res_order_next = OW'(p_reg);
                    state_next     = S_DONE;
                end
            end
            S_FREE_RD:
            begin
                s_next         = ht_rdata[AW+OW-1:OW];
                k_next         = KW'(ht_rdata[OW-1:0]);
                res_start_next = ht_rdata[AW+OW-1:OW];
                res_order_next = ht_rdata[OW-1:0];
                clr_valid      = 1'b1;
                state_next     = S_FREE_BASE;
            end
            S_FREE_BASE:
            begin
                if (p_reg < k_reg)
                begin
                    base_next = base_reg + BW'(lim_p);
                    p_next    = p_reg + KW'(1);
                end
                else
                begin
                    state_next = S_MERGE_RD;
                end
            end
            S_MERGE_RD:
            begin
                fr_raddr = addr_of(base_reg, bidx);
                if ((k_reg >= MAX_K) || (bidx >= lim_k))
                begin
                    state_next = S_MERGE_END;
                end
                else
                begin
                    state_next = S_MERGE_CHK;
                end
            end
            S_MERGE_CHK:
            begin
                if (fr_rdata)
                begin
                    fr_we      = 1'b1;
                    fr_wdata   = 1'b0;
                    fr_waddr   = addr_of(base_reg, bidx);
                    s_next     = s_reg & ~(AW'(1) << k_reg);
                    base_next  = base_reg + BW'(lim_k);
                    k_next     = k_reg + KW'(1);
                    state_next = S_MERGE_RD;
                end
                else
                begin
                    state_next = S_MERGE_END;
                end
            end
            S_MERGE_END:
            begin
                if (sidx < lim_k)
                begin
                    fr_we    = 1'b1;
                    fr_wdata = 1'b1;
                    fr_waddr = addr_of(base_reg, sidx);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            bc_reg        <= 11'd1024;
            sw_addr_reg   <= '0;
            sw_i_reg      <= '0;
            sw_k_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            hvalid_reg    <= '0;
        end
        else
        begin
            if (block_count_we)
            begin
                bc_reg      <= block_count;
                state_reg   <= S_SWEEP;
                sw_addr_reg <= '0;
                sw_i_reg    <= '0;
                sw_k_reg    <= '0;
                hvalid_reg  <= '0;
            end
            else
            begin
                state_reg <= state_next;
                if (state_reg == S_SWEEP)
                begin
                    sw_addr_reg <= sw_addr_reg + DAW'(1);
                    if (sw_i_reg + (AW+1)'(1) >= sw_lim)
                    begin
                        sw_i_reg <= '0;
                        sw_k_reg <= sw_k1;
                    end
                    else
                    begin
                        sw_i_reg <= sw_i_reg + (AW+1)'(1);
                    end
                end
                if (set_valid)
                begin
                    hvalid_reg[hidx] <= 1'b1;
                end
                if (clr_valid)
                begin
                    hvalid_reg[hidx] <= 1'b0;
                end
            end
            if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        h_reg          <= h_next;
        size_reg       <= size_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        base_reg       <= base_next;
        i_reg          <= i_next;
        s_reg          <= s_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_order_reg  <= res_order_next;
        if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_status_reg <= res_status_reg;
            rsp_start_reg  <= res_start_reg;
            rsp_order_reg  <= res_order_reg;
        end
    end

    bba_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_free_store (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    bba_ram #(
        .WIDTH (AW + OW),
        .DEPTH (HANDLES)
    ) u_handle_table (
        .clk   (clk),
        .we    (ht_we),
        .waddr (hidx),
        .wdata (ht_wdata),
        .raddr (hidx),
        .rdata (ht_rdata)
    );

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign start_block = rsp_start_reg;
    assign order       = rsp_order_reg;

endmodule

// ===== tb/buddy_block_allocator_tb.sv =====
// Self-checking testbench for the buddy block allocator with a scoreboard class.
`timescale 1ns / 1ps

module buddy_block_allocator_tb;

    import bba_pkg::*;

    localparam int BLOCKS    = 1024;
    localparam int MAX_ORDER = 10;
    localparam int HANDLES   = 256;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        status_t    st;
        logic [9:0] start;
        logic [3:0] ord;
    } alloc_result_t;

    class alloc_scoreboard;
        bit            free_map [MAX_ORDER+1][BLOCKS];
        bit            held     [HANDLES];
        int            held_start [HANDLES];
        int            held_order [HANDLES];
        alloc_result_t pending_results [$];
        int            errors;

        function void rebuild(int count);
            int n;
            int pos;
            n = (count > BLOCKS) ? BLOCKS : count;
            pos = 0;
            foreach (free_map[k, i]) free_map[k][i] = 0;
            foreach (held[h]) held[h] = 0;
            for (int k = MAX_ORDER; k >= 0; k--)
            begin
                while (n - pos >= (1 << k))
                begin
                    free_map[k][pos >> k] = 1;
                    pos += 1 << k;
                end
            end
        endfunction

        function void note_request(bit fn, int h, int size);
            alloc_result_t r;
            int p;
            int q;
            int idx;
            int s;
            int k;
            int b;
            bit found;
            r = '0;
            if (fn == 1'b0)
            begin
                if (held[h])
                    r.st = ST_HANDLE_BUSY;
                else if (size == 0)
                    r.st = ST_BAD_SIZE;
                else if (size > (1 << MAX_ORDER))
                    r.st = ST_NO_SPACE;
                else
                begin
                    p = 0;
                    while ((1 << p) < size) p++;
                    found = 0;
                    idx = 0;
                    for (q = p; q <= MAX_ORDER; q++)
                    begin
                        for (idx = 0; idx < (BLOCKS >> q); idx++)
                            if (free_map[q][idx])
                            begin
                                found = 1;
                                break;
                            end
                        if (found) break;
                    end
                    if (!found)
                        r.st = ST_NO_SPACE;
                    else
                    begin
                        free_map[q][idx] = 0;
                        s = idx << q;
                        while (q > p)
                        begin
                            q--;
                            free_map[q][(s + (1 << q)) >> q] = 1;
                        end
                        held[h] = 1;
                        held_start[h] = s;
                        held_order[h] = p;
                        r.st = ST_OK;
                        r.start = 10'(s);
                        r.ord = 4'(p);
                    end
                end
            end
            else
            begin
                if (!held[h])
                    r.st = ST_NOT_HELD;
                else
                begin
                    s = held_start[h];
                    k = held_order[h];
                    r.st = ST_OK;
                    r.start = 10'(s);
                    r.ord = 4'(k);
                    held[h] = 0;
                    while (k < MAX_ORDER)
                    begin
                        b = s ^ (1 << k);
                        if ((b >> k) >= (BLOCKS >> k) || !free_map[k][b >> k]) break;
                        free_map[k][b >> k] = 0;
                        s &= ~(1 << k);
                        k++;
                    end
                    if ((s >> k) < (BLOCKS >> k))
                        free_map[k][s >> k] = 1;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(status_t st, logic [9:0] start, logic [3:0] ord);
            alloc_result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d start %0d order %0d",
                         $time, st, start, ord);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
            if (start !== e.start)
            begin
                $display("%0t: start_block expected %0d actual %0d", $time, e.start, start);
                errors++;
            end
            if (ord !== e.ord)
            begin
                $display("%0t: order expected %0d actual %0d", $time, e.ord, ord);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        block_count_we;
    logic [10:0] block_count;
    logic        req_valid;
    logic        req_stall;
    logic        func;
    logic [7:0]  handle;
    logic [10:0] request_size;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    status_t     status;
    logic [9:0]  start_block;
    logic [3:0]  order;

    alloc_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles = 0;

    buddy_block_allocator #(
        .BLOCKS    (BLOCKS),
        .MAX_ORDER (MAX_ORDER),
        .HANDLES   (HANDLES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .block_count_we (block_count_we),
        .block_count    (block_count),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .handle         (handle),
        .request_size   (request_size),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .start_block    (start_block),
        .order          (order)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_off)
        begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(status, start_block, order);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL buddy_block_allocator");
            $finish;
        end
    end

    task automatic send_request(bit fn, int h, int size);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        req_valid    <= 1'b1;
        func         <= fn;
        handle       <= 8'(h);
        request_size <= 11'(size);
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(fn, h, size);
    endtask

    task automatic drain();
        if (req_valid)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_block_count(int value);
        drain();
        repeat (20) @(posedge clk);
        block_count_we <= 1'b1;
        block_count    <= 11'(value);
        @(posedge clk);
        block_count_we <= 1'b0;
        sb.rebuild(value & 11'h7FF);
    endtask

    task automatic random_traffic(int count);
        int h;
        int size;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            h = (pick < 85) ? $urandom_range(31) : $urandom_range(255);
            pick = $urandom_range(99);
            if (pick < 60) size = $urandom_range(1, 16);
            else if (pick < 85) size = $urandom_range(1, 256);
            else if (pick < 95) size = $urandom_range(1, 1024);
            else size = $urandom_range(0, 2047);
            send_request($urandom_range(99) < 45, h, size);
        end
    endtask

    initial
    begin
        sb = new();
        sb.rebuild(1024);
        rst_n          = 1'b0;
        block_count_we = 1'b0;
        block_count    = 11'd1024;
        req_valid      = 1'b0;
        func           = 1'b0;
        handle         = '0;
        request_size   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_request(0, 0, 0);
        send_request(0, 0, 1);
        send_request(0, 0, 1);
        send_request(0, 0, 0);
        send_request(0, 1, 1025);
        send_request(0, 2, 1024);
        send_request(1, 0, 0);
        send_request(1, 0, 2047);
        send_request(0, 255, 1024);
        send_request(1, 255, 2047);
        send_request(0, 7, 3);
        send_request(0, 8, 512);
        send_request(0, 9, 2047);
        send_request(1, 7, 5);
        send_request(1, 8, 0);
        write_block_count(0);
        send_request(0, 3, 1);
        write_block_count(2047);
        send_request(0, 4, 1024);
        write_block_count(1);
        send_request(0, 5, 1);
        send_request(0, 6, 1);
        send_request(1, 5, 1);

        write_block_count(1024);
        random_traffic(480);
        send_idle_pct = 45;
        write_block_count(700);
        random_traffic(480);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        write_block_count(37);
        hold_off = 1'b1;
        random_traffic(470);
        drain();
        send_idle_pct = 31;
        recv_stall_pct = 31;
        write_block_count(1024);
        random_traffic(470);

        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS buddy_block_allocator");
        else
            $display("FAIL buddy_block_allocator");
        $finish;
    end

endmodule

// ===== buddy_block_allocator.f =====
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/buddy_block_allocator.sv
tb/buddy_block_allocator_tb.sv
